// ----- rtl/mact_pkg.sv -----
package mact_pkg;

   // Default sizes of the two windows and of a stored price
   localparam int SHORT_LEN_DEF  = 16;
   localparam int LONG_LEN_DEF   = 64;
   localparam int PRICE_BITS_DEF = 32;

   // Fixed field widths
   localparam int TYPE_BITS  = 2;
   localparam int INPUT_BITS = 32;
   localparam int QTY_BITS   = 33;
   localparam int CFG_BITS   = 32;

   // Request type codes
   localparam logic [TYPE_BITS-1:0] REQ_TRADE    = 2'd0;
   localparam logic [TYPE_BITS-1:0] REQ_POSITION = 2'd1;
   localparam logic [TYPE_BITS-1:0] REQ_TICK     = 2'd2;

   // Register map
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_MAX_QTY    = 2'd0;
   localparam logic [1:0] REG_BASE_QTY   = 2'd1;
   localparam logic [1:0] REG_CONTRARIAN = 2'd2;

   localparam logic [CFG_BITS-1:0] UNLIMITED_QTY = 32'hFFFF_FFFF;
   localparam logic [CFG_BITS-1:0] BASE_QTY_RST  = 32'd100;

   typedef struct packed {
      logic [CFG_BITS-1:0] max_quantity;
      logic [CFG_BITS-1:0] base_quantity;
      logic                contrarian;
   } cfg_type;

   typedef struct packed {
      logic s1_valid;   // a tick waits in the decision stage
      logic stall;      // decision stage blocked by a full output register
      logic held_sign;
   } dstat_type;

endpackage

// ----- rtl/mact_req_if.sv -----
interface mact_req_if import mact_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [TYPE_BITS-1:0]         req_type;
   logic signed [INPUT_BITS-1:0] trade_price;
   logic signed [INPUT_BITS-1:0] position;

   modport source (output valid, req_type, trade_price, position, input ready);
   modport sink   (input valid, req_type, trade_price, position, output ready);
endinterface

// ----- rtl/mact_rsp_if.sv -----
interface mact_rsp_if import mact_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       order_side;
   logic signed [QTY_BITS-1:0] order_quantity;

   modport source (output valid, order_side, order_quantity, input ready);
   modport sink   (input valid, order_side, order_quantity, output ready);
endinterface

// ----- rtl/mact_csr.sv -----
module mact_csr import mact_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MAX_QTY:    cfg_in.max_quantity  = pwdata;
            REG_BASE_QTY:   cfg_in.base_quantity = pwdata;
            REG_CONTRARIAN: cfg_in.contrarian    = pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MAX_QTY:    prdata = cfg_ff.max_quantity;
         REG_BASE_QTY:   prdata = cfg_ff.base_quantity;
         REG_CONTRARIAN: prdata = {{(CSR_DATA_BITS-1){1'b0}}, cfg_ff.contrarian};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_quantity  <= UNLIMITED_QTY;
         cfg_ff.base_quantity <= BASE_QTY_RST;
         cfg_ff.contrarian    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/mact_ring.sv -----
module mact_ring import mact_pkg::*; #(
   parameter  int LEN        = SHORT_LEN_DEF,
   parameter  int PRICE_BITS = PRICE_BITS_DEF,
   localparam int IW         = $clog2(LEN),
   localparam int TW         = PRICE_BITS + $clog2(LEN) + 1,
   localparam int CW         = $clog2(LEN + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic                         push_known,
   input  logic signed [PRICE_BITS-1:0] push_price,
   output logic signed [TW-1:0]         total,
   output logic                         unknown_any
);

   // entry: {known, price}; unknown entries hold a zero price
   logic [PRICE_BITS:0]          mem [LEN];
   logic [PRICE_BITS:0]          rd_ff;
   logic [IW-1:0]                idx_ff, idx_in;
   logic                         full_ff, full_in;
   logic signed [TW-1:0]         total_ff, total_in;
   logic [CW-1:0]                unk_ff, unk_in;
   logic                         wrap;
   logic                         old_known;
   logic signed [PRICE_BITS-1:0] old_price, new_price;

   assign total       = total_ff;
   assign unknown_any = (unk_ff != '0);

   always_comb begin
      wrap    = (idx_ff == IW'(LEN - 1));
      idx_in  = idx_ff;
      full_in = full_ff;
      if (push) begin
         idx_in = wrap ? '0 : idx_ff + IW'(1);
         if (wrap) begin
            full_in = 1'b1;
         end
      end
      // until the first wrap the slot is taken as zero, known, whatever it holds
      old_known = full_ff ? rd_ff[PRICE_BITS] : 1'b1;
      old_price = full_ff ? signed'(rd_ff[PRICE_BITS-1:0]) : '0;
      new_price = push_known ? push_price : '0;
      total_in  = total_ff;
      unk_in    = unk_ff;
      if (push) begin
         total_in = total_ff - TW'(old_price) + TW'(new_price);
         unk_in   = unk_ff - CW'(!old_known) + CW'(!push_known);
      end
   end

   // Prefetch the slot that the next push overwrites. On a push the read address
   // is one past the written slot, so read and write never collide.
   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_in];
      if (push) begin
         mem[idx_ff] <= {push_known, new_price};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         full_ff  <= 1'b0;
         total_ff <= '0;
         unk_ff   <= '0;
      end else begin
         idx_ff   <= idx_in;
         full_ff  <= full_in;
         total_ff <= total_in;
         unk_ff   <= unk_in;
      end
   end

endmodule

// ----- rtl/mact_decide.sv -----
module mact_decide import mact_pkg::*; #(
   parameter  int SHORT_LEN  = SHORT_LEN_DEF,
   parameter  int LONG_LEN   = LONG_LEN_DEF,
   parameter  int PRICE_BITS = PRICE_BITS_DEF,
   localparam int STW        = PRICE_BITS + $clog2(SHORT_LEN) + 1,
   localparam int LTW        = PRICE_BITS + $clog2(LONG_LEN) + 1,
   localparam int CMPW       = PRICE_BITS + $clog2(SHORT_LEN) + $clog2(LONG_LEN) + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick,
   input  logic signed [INPUT_BITS-1:0] position,
   input  logic signed [STW-1:0]        short_total,
   input  logic signed [LTW-1:0]        long_total,
   input  logic                         short_unknown,
   input  logic                         long_unknown,
   input  cfg_type                      cfg,
   mact_rsp_if.source                   rsp_if,
   output dstat_type                    dstat
);

   localparam int QW = QTY_BITS + 2;
   localparam logic signed [QW-1:0] QTY_CEIL = 35'sd4294967295;

   logic                         s1_valid_ff, s1_valid_in;
   logic [INPUT_BITS-1:0]        mag_ff, mag_in;
   logic                         held_sign_ff, held_sign_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         side_ff;
   logic signed [QTY_BITS-1:0]   qty_ff;
   logic                         stall, fire, trend;
   logic signed [CMPW-1:0]       lhs, rhs;
   logic signed [QW-1:0]         q_sum, q_cap, q_min, q_sat;

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.order_side     = side_ff;
   assign rsp_if.order_quantity = qty_ff;

   assign dstat.s1_valid  = s1_valid_ff;
   assign dstat.stall     = stall;
   assign dstat.held_sign = held_sign_ff;

   always_comb begin
      // |position|; the most negative value maps to 2^31, still in 32 bits
      mag_in = position[INPUT_BITS-1] ? INPUT_BITS'(-position) : position;

      // short mean below long mean, compared without division
      lhs   = CMPW'(short_total) * $signed(CMPW'(LONG_LEN));
      rhs   = CMPW'(long_total) * $signed(CMPW'(SHORT_LEN));
      trend = (short_unknown || long_unknown) ? 1'b0 : (lhs < rhs);

      stall = s1_valid_ff && out_valid_ff && !rsp_if.ready;
      fire  = s1_valid_ff && !stall && (trend != held_sign_ff);

      q_sum = $signed({3'b000, mag_ff}) + $signed({3'b000, cfg.base_quantity});
      q_cap = $signed({3'b000, cfg.max_quantity}) - $signed({3'b000, mag_ff});
      q_min = ((cfg.max_quantity != UNLIMITED_QTY) && (q_cap < q_sum)) ? q_cap : q_sum;
      q_sat = (q_min > QTY_CEIL) ? QTY_CEIL : q_min;

      s1_valid_in  = tick || stall;
      held_sign_in = fire ? trend : held_sign_ff;
      out_valid_in = fire || (out_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         mag_ff <= mag_in;
      end
      if (fire) begin
         side_ff <= trend ^ cfg.contrarian;
         qty_ff  <= q_sat[QTY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         held_sign_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         held_sign_ff <= held_sign_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- rtl/moving_average_crossover_trigger.sv -----
// Moving-average crossover trigger.
// req_if carries one item per handshake: a trade price update, a position
// update or a tick. Price and position updates only refresh held values.
// A tick pushes the last traded price into a short and a long ring (each a
// synchronous RAM with a running total) and may cause one market order on
// rsp_if when the trend sign flips: side and signed quantity.
// Throughput: one item per cycle while req_if.ready is high. A tick updates
// the ring totals at its accept edge; the decision stage compares the means in
// the next cycle; the output register, which drives rsp_if.valid, loads once free.
// The ring read of the slot to overwrite is prefetched into a register, so
// back-to-back ticks need no bubble.
// When the receiver stalls, one more tick may enter the decision stage;
// req_if.ready then drops until the output register is freed.
// Reset (synchronous, active high) empties both rings by clearing their fill
// flags, clears totals and held state and loads the register defaults: no cap,
// base quantity 100, trend side. No clearing pass is needed. The user writes
// configuration over the APB port only while the block is idle (not enforced).
module moving_average_crossover_trigger import mact_pkg::*; #(
   parameter int SHORT_LEN  = SHORT_LEN_DEF,
   parameter int LONG_LEN   = LONG_LEN_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   mact_req_if.sink                 req_if,
   mact_rsp_if.source               rsp_if,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int STW = PRICE_BITS + $clog2(SHORT_LEN) + 1;
   localparam int LTW = PRICE_BITS + $clog2(LONG_LEN) + 1;

   cfg_type                      cfg;
   dstat_type                    dstat;
   logic                         req_accept, tick;
   logic signed [PRICE_BITS-1:0] new_price;
   logic signed [PRICE_BITS-1:0] last_price_ff;
   logic                         price_known_ff;
   logic signed [INPUT_BITS-1:0] held_position_ff;
   logic signed [STW-1:0]        short_total;
   logic signed [LTW-1:0]        long_total;
   logic                         short_unknown, long_unknown;

   // Hold off every item while the decision stage is blocked
   assign req_if.ready = !dstat.stall;
   assign req_accept   = req_if.valid && req_if.ready;
   assign tick         = req_accept && (req_if.req_type == REQ_TICK);

   // Keep the low PRICE_BITS of the price, or zero extend it when PRICE_BITS is wider
   if (PRICE_BITS <= INPUT_BITS) begin : g_price_narrow
      assign new_price = req_if.trade_price[PRICE_BITS-1:0];
   end else begin : g_price_wide
      assign new_price = PRICE_BITS'(unsigned'(req_if.trade_price));
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_if.req_type == REQ_TRADE)) begin
         last_price_ff <= new_price;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         price_known_ff   <= 1'b0;
         held_position_ff <= '0;
      end else begin
         if (req_accept && (req_if.req_type == REQ_TRADE)) begin
            price_known_ff <= 1'b1;
         end
         if (req_accept && (req_if.req_type == REQ_POSITION)) begin
            held_position_ff <= req_if.position;
         end
      end
   end

   mact_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Before the first trade each tick pushes an unknown entry
   mact_ring #(.LEN(SHORT_LEN), .PRICE_BITS(PRICE_BITS)) u_short_ring (
      .clock       (clock),
      .reset       (reset),
      .push        (tick),
      .push_known  (price_known_ff),
      .push_price  (last_price_ff),
      .total       (short_total),
      .unknown_any (short_unknown)
   );

   mact_ring #(.LEN(LONG_LEN), .PRICE_BITS(PRICE_BITS)) u_long_ring (
      .clock       (clock),
      .reset       (reset),
      .push        (tick),
      .push_known  (price_known_ff),
      .push_price  (last_price_ff),
      .total       (long_total),
      .unknown_any (long_unknown)
   );

   mact_decide #(
      .SHORT_LEN  (SHORT_LEN),
      .LONG_LEN   (LONG_LEN),
      .PRICE_BITS (PRICE_BITS)
   ) u_decide (
      .clock         (clock),
      .reset         (reset),
      .tick          (tick),
      .position      (held_position_ff),
      .short_total   (short_total),
      .long_total    (long_total),
      .short_unknown (short_unknown),
      .long_unknown  (long_unknown),
      .cfg           (cfg),
      .rsp_if        (rsp_if),
      .dstat         (dstat)
   );

   // An accepted tick always reaches the decision stage
   a_tick_enters: assert property (@(posedge clock) disable iff (reset)
      tick |=> dstat.s1_valid)
      else $error("accepted tick did not enter the decision stage");

   // The held sign only moves together with an issued order
   a_sign_with_order: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (dstat.held_sign != $past(dstat.held_sign))) |-> rsp_if.valid)
      else $error("held sign changed without an order");

   // No order before any trade price was seen
   a_no_order_unpriced: assert property (@(posedge clock) disable iff (reset)
      !price_known_ff |-> (!rsp_if.valid && !dstat.held_sign))
      else $error("order issued before the first trade");

endmodule

// ----- sim/testbench.sv -----
`default_nettype none

module testbench import mact_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // Request code that the block ignores, and the register slot past the map
   localparam logic [TYPE_BITS-1:0] REQ_UNUSED = 2'd3;
   localparam logic [1:0]           REG_SPARE  = 2'd3;

   localparam int     SEND_ITEMS    = 1950;  // stop feeding once this many are queued
   localparam int     PHASE_ITEMS   = 250;
   localparam int     MAX_PHASES    = 40;
   localparam int     MAX_WAIT      = 19;
   localparam int     SETTLE_CYCLES = MAX_WAIT + 8;  // longest take stall, with margin
   localparam int     QUIET_LIMIT   = 2000;

   localparam longint QTY_CEIL  = 64'sd4294967295;
   localparam longint PX_TOP    = 64'sd2147483647;
   localparam longint PX_BOTTOM = -64'sd2147483648;

   typedef struct packed {
      logic [TYPE_BITS-1:0]         kind;
      logic signed [INPUT_BITS-1:0] price;
      logic signed [INPUT_BITS-1:0] pos;
   } market_req_type;

   typedef struct packed {
      logic                       side;
      logic signed [QTY_BITS-1:0] qty;
   } order_type;

   logic clock = 1'b0;
   logic reset;

   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   mact_req_if req_bus ();
   mact_rsp_if rsp_bus ();

   moving_average_crossover_trigger u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Trend tracker: own copy of both windows, held values and settings
   // ---------------------------------------------------------------------
   logic signed [INPUT_BITS-1:0] short_px [SHORT_LEN_DEF];
   bit                           short_ok [SHORT_LEN_DEF];
   logic signed [INPUT_BITS-1:0] long_px  [LONG_LEN_DEF];
   bit                           long_ok  [LONG_LEN_DEF];
   int                           short_slot, long_slot;
   longint                       short_sum, long_sum;
   int                           short_unknown, long_unknown;
   logic signed [INPUT_BITS-1:0] last_px;
   bit                           px_seen;
   logic signed [INPUT_BITS-1:0] pos_held;
   logic                         sign_held;

   logic [CFG_BITS-1:0] cfg_max_qty;
   logic [CFG_BITS-1:0] cfg_base_qty;
   logic                cfg_contrarian;

   order_type orders_due [$];   // orders the tracker has issued, oldest first

   // Work out what one accepted item does; queue the order if the trend flips.
   task automatic advance_trend(input market_req_type r);
      longint    mag, qty, cap;
      logic      trend;
      order_type o;
      case (r.kind)
         REQ_TRADE: begin
            last_px = r.price;
            px_seen = 1'b1;
         end
         REQ_POSITION: begin
            pos_held = r.pos;
         end
         REQ_TICK: begin
            // Retire the oldest short entry, then push the last price (or unknown)
            if (short_ok[short_slot]) short_sum -= longint'(short_px[short_slot]);
            else short_unknown--;
            short_px[short_slot] = px_seen ? last_px : '0;
            short_ok[short_slot] = px_seen;
            if (px_seen) short_sum += longint'(last_px);
            else short_unknown++;
            short_slot = (short_slot + 1) % SHORT_LEN_DEF;

            if (long_ok[long_slot]) long_sum -= longint'(long_px[long_slot]);
            else long_unknown--;
            long_px[long_slot] = px_seen ? last_px : '0;
            long_ok[long_slot] = px_seen;
            if (px_seen) long_sum += longint'(last_px);
            else long_unknown++;
            long_slot = (long_slot + 1) % LONG_LEN_DEF;

            // Short mean below long mean, cross-multiplied to stay exact;
            // any unknown entry in either window forces the flat sign.
            trend = (short_unknown == 0) && (long_unknown == 0) &&
                    (short_sum * LONG_LEN_DEF < long_sum * SHORT_LEN_DEF);

            if (trend != sign_held) begin
               mag = (pos_held < 0) ? -longint'(pos_held) : longint'(pos_held);
               qty = mag + longint'(cfg_base_qty);
               if (cfg_max_qty != UNLIMITED_QTY) begin
                  cap = longint'(cfg_max_qty) - mag;
                  if (cap < qty) qty = cap;
               end
               if (qty > QTY_CEIL) qty = QTY_CEIL;
               o.side = trend ^ cfg_contrarian;
               o.qty  = qty[QTY_BITS-1:0];
               orders_due.push_back(o);
               sign_held = trend;
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Bookkeeping
   // ---------------------------------------------------------------------
   int mismatches    = 0;
   int orders_seen   = 0;
   int items_sent    = 0;   // queued items the block acts on (unused code excluded)
   int reqs_queued   = 0;
   int reqs_accepted = 0;

   task automatic flag_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: pop the pending items; unless steady, idle between them at random
   // ---------------------------------------------------------------------
   market_req_type pending_reqs [$];
   market_req_type cur_req;
   int             send_gap;
   bit             send_steady;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         // Predict on the item that the block takes at this edge
         if (req_bus.valid && req_bus.ready) begin
            advance_trend(cur_req);
            reqs_accepted++;
         end
         // Refill only when the bus slot frees up; one assignment per signal
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.req_type    <= cur_req.kind;
               req_bus.trade_price <= cur_req.price;
               req_bus.position    <= cur_req.pos;
               send_gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Order monitor: after each take, draw a stall (zero when steady) that counts
   // down while an order is shown; take each order and compare with the oldest order due
   // ---------------------------------------------------------------------
   int        take_gap;
   bit        take_steady;
   order_type due;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            orders_seen++;
            if (orders_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected order: side %0b qty %0d",
                                       rsp_bus.order_side, rsp_bus.order_quantity));
            end else begin
               due = orders_due.pop_front();
               if (rsp_bus.order_side !== due.side)
                  flag_mismatch($sformatf("order %0d side: got %0b want %0b",
                                          orders_seen, rsp_bus.order_side, due.side));
               if (rsp_bus.order_quantity !== due.qty)
                  flag_mismatch($sformatf("order %0d quantity: got %0d want %0d",
                                          orders_seen, rsp_bus.order_quantity, due.qty));
            end
            take_gap = take_steady ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (rsp_bus.valid && take_gap != 0) begin
            // count the stall only while an order is actually waiting
            take_gap--;
         end
         rsp_bus.ready <= (take_gap == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("moving_average_crossover_trigger regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   longint walk_px;   // center of the price random walk

   task automatic queue_req(input logic [TYPE_BITS-1:0] kind,
                            input logic [INPUT_BITS-1:0] price,
                            input logic [INPUT_BITS-1:0] pos);
      market_req_type r;
      r.kind  = kind;
      r.price = price;
      r.pos   = pos;
      pending_reqs.push_back(r);
      reqs_queued++;
      if (kind != REQ_UNUSED) items_sent++;
   endtask

   // Flat, small and random positions, with the signed extremes mixed in
   function automatic logic [INPUT_BITS-1:0] pick_position();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         3:       return $urandom_range(0, 1) ? $urandom_range(0, 2000)
                                              : -$urandom_range(0, 2000);
         default: return $urandom;
      endcase
   endfunction

   // Trending legs of trades and ticks; each leg flips direction at random so
   // the two averages cross. Sprinkle position updates, wild trades and
   // unused codes in between.
   task automatic queue_market(input int budget);
      int     pick;
      int     leg_left;
      longint slope;
      leg_left = 0;
      slope    = 0;
      while (budget > 0) begin
         if (leg_left == 0) begin
            leg_left = $urandom_range(12, 90);
            slope    = longint'($urandom_range(1, 1 << $urandom_range(0, 18)));
            if ($urandom_range(0, 1)) slope = -slope;
            if ($urandom_range(0, 5) == 0) walk_px = longint'(int'($urandom));
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            queue_req(REQ_TICK, $urandom, $urandom);
            leg_left--;
         end else if (pick < 85) begin
            walk_px += slope + longint'($urandom_range(0, 16)) - 8;
            // bounce off the price range instead of wrapping
            if (walk_px > PX_TOP) begin
               walk_px = PX_TOP;
               slope   = -slope;
            end else if (walk_px < PX_BOTTOM) begin
               walk_px = PX_BOTTOM;
               slope   = -slope;
            end
            queue_req(REQ_TRADE, walk_px[INPUT_BITS-1:0], $urandom);
         end else if (pick < 93) begin
            queue_req(REQ_POSITION, $urandom, pick_position());
         end else if (pick < 97) begin
            queue_req(REQ_TRADE, $urandom, $urandom);
         end else begin
            queue_req(REQ_UNUSED, $urandom, $urandom);
         end
         if (pick < 97) budget--;
      end
   endtask

   // One APB transfer: setup, then access until pready. Check read data.
   task automatic csr_access(input logic is_write, input logic [1:0] index,
                             input logic [CSR_DATA_BITS-1:0] data);
      logic [CSR_DATA_BITS-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (!is_write && got !== data)
         flag_mismatch($sformatf("register %0d read %0h want %0h", index, got, data));
   endtask

   // Write all three registers, mirror them in the tracker, read them back
   task automatic apply_settings(input logic [CFG_BITS-1:0] max_qty,
                                 input logic [CFG_BITS-1:0] base_qty,
                                 input logic contrarian);
      csr_access(1'b1, REG_MAX_QTY, max_qty);
      cfg_max_qty = max_qty;
      csr_access(1'b1, REG_BASE_QTY, base_qty);
      cfg_base_qty = base_qty;
      csr_access(1'b1, REG_CONTRARIAN, {31'd0, contrarian});
      cfg_contrarian = contrarian;
      csr_access(1'b0, REG_MAX_QTY, max_qty);
      csr_access(1'b0, REG_BASE_QTY, base_qty);
      csr_access(1'b0, REG_CONTRARIAN, {31'd0, contrarian});
   endtask

   // Wait until every item is taken and every order is back, then let the
   // decision stage empty out before touching the registers.
   task automatic drain_and_settle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || reqs_accepted != reqs_queued ||
             orders_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   int phase;
   int phase_budget;

   initial begin
      // Drive every input to a known value at time zero
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = REQ_TRADE;
      req_bus.trade_price = '0;
      req_bus.position    = '0;
      rsp_bus.ready       = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;

      // Tracker starts as the block does out of reset: known zero windows
      for (int i = 0; i < SHORT_LEN_DEF; i++) begin
         short_px[i] = '0;
         short_ok[i] = 1'b1;
      end
      for (int i = 0; i < LONG_LEN_DEF; i++) begin
         long_px[i] = '0;
         long_ok[i] = 1'b1;
      end
      short_slot     = 0;
      long_slot      = 0;
      short_sum      = 0;
      long_sum       = 0;
      short_unknown  = 0;
      long_unknown   = 0;
      last_px        = '0;
      px_seen        = 1'b0;
      pos_held       = '0;
      sign_held      = 1'b0;
      cfg_max_qty    = UNLIMITED_QTY;
      cfg_base_qty   = BASE_QTY_RST;
      cfg_contrarian = 1'b0;
      walk_px        = 0;
      send_steady    = 1'b0;
      take_steady    = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Check the register defaults
      csr_access(1'b0, REG_MAX_QTY, UNLIMITED_QTY);
      csr_access(1'b0, REG_BASE_QTY, BASE_QTY_RST);
      csr_access(1'b0, REG_CONTRARIAN, '0);

      // Directed: ticks before any trade push unknown entries, an unused
      // code, both price extremes and both position extremes
      @(negedge clock);
      queue_req(REQ_TICK, '0, '0);
      queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(REQ_POSITION, '0, 32'h8000_0000);
      queue_req(REQ_TICK, '0, '0);
      queue_req(REQ_TRADE, 32'h7FFF_FFFF, '0);
      queue_req(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(REQ_TRADE, 32'h8000_0000, '0);
      queue_req(REQ_POSITION, '0, 32'h7FFF_FFFF);
      queue_req(REQ_TICK, '0, '0);
      queue_req(REQ_TRADE, '0, '0);
      queue_req(REQ_POSITION, '0, '0);
      queue_req(REQ_TICK, '0, '0);
      queue_req(REQ_TRADE, 32'hFFFF_FFFF, '0);
      queue_req(REQ_TICK, '0, '0);
      queue_req(REQ_TICK, '0, '0);
      drain_and_settle();

      // Random phases, each under its own settings; cycle through the
      // extremes (no cap, zero cap, tiny base, zero base, saturating base)
      phase = 0;
      while (items_sent < SEND_ITEMS && phase < MAX_PHASES) begin
         case (phase % 6)
            0: apply_settings(UNLIMITED_QTY, BASE_QTY_RST, 1'b0);
            1: apply_settings('0, 32'd1, 1'b1);
            2: apply_settings(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
            3: apply_settings($urandom_range(0, 5000), '0, 1'b1);
            4: apply_settings(UNLIMITED_QTY, 32'hFFFF_FFFF, 1'b1);
            default: begin
               apply_settings($urandom, $urandom, 1'($urandom_range(0, 1)));
               // the slot past the map must change nothing
               csr_access(1'b1, REG_SPARE, $urandom);
            end
         endcase
         @(negedge clock);
         send_steady = ($urandom_range(0, 2) == 0);
         take_steady = ($urandom_range(0, 2) == 0);
         phase_budget = SEND_ITEMS - items_sent;
         if (phase_budget > PHASE_ITEMS) phase_budget = PHASE_ITEMS;
         queue_market(phase_budget);
         drain_and_settle();
         phase++;
      end

      if (mismatches == 0) begin
         $display("moving_average_crossover_trigger regression: pass");
      end else begin
         $display("moving_average_crossover_trigger regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
